[hw/rtl/dsa_pkg.sv]
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and codes for the DSA sign and verify unit: operation codes of
// the shared modular arithmetic unit and configuration register indexes.
// ----------------------------------------------------------------------------
package dsa_pkg;

  // operation codes of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_MUL = 2'b01,  // a * b mod m, shift-add, one bit of b a cycle
    OP_DIV = 2'b10   // a / m and a % m, restoring, one quotient bit a cycle
  } op_t;

  // configuration register indexes
  localparam logic [1:0] REG_P = 2'd0;
  localparam logic [1:0] REG_Q = 2'd1;
  localparam logic [1:0] REG_G = 2'd2;
  localparam logic [1:0] REG_X = 2'd3;

endpackage

[hw/rtl/dsa_arith.sv]
// ----------------------------------------------------------------------------
// dsa_arith
// Shared bit-serial modular unit: modular multiply (a, acc below m) or
// unsigned divide with remainder; done pulses after the last iteration.
// ----------------------------------------------------------------------------
module dsa_arith #(
  parameter int W = 31
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dsa_pkg::op_t    op,
  input  logic [W-1:0]    a,
  input  logic [W-1:0]    b,
  input  logic [W-1:0]    m,
  output logic            done,
  output logic [W-1:0]    quo,
  output logic [W-1:0]    rem
);

  localparam int CW = $clog2(W + 1);

  logic              running;
  logic [CW-1:0]     cnt;
  dsa_pkg::op_t      op_r;
  logic [W-1:0]      acc;
  logic [W-1:0]      x;
  logic [W-1:0]      y;
  logic [W-1:0]      md;

  logic [W:0]        sum_add;
  logic [W-1:0]      acc_add;
  logic [W:0]        sum_dbl;
  logic [W-1:0]      x_dbl;
  logic [W:0]        div_t;
  logic              div_ge;
  logic [W:0]        div_sub;

  // add-mod for the accumulator and the doubled operand, restoring step
  always_comb begin
    sum_add = {1'b0, acc} + {1'b0, x};
    acc_add = (sum_add >= {1'b0, md}) ? W'(sum_add - {1'b0, md}) : sum_add[W-1:0];
    sum_dbl = {1'b0, x} + {1'b0, x};
    x_dbl   = (sum_dbl >= {1'b0, md}) ? W'(sum_dbl - {1'b0, md}) : sum_dbl[W-1:0];
    div_t   = {acc, x[W-1]};
    div_ge  = (div_t >= {1'b0, md});
    div_sub = div_t - {1'b0, md};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(W);
      end else if (running) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= op;
      acc  <= '0;
      x    <= a;
      y    <= b;
      md   <= m;
    end else if (running) begin
      unique case (op_r)
        dsa_pkg::OP_MUL: begin
          if (y[0]) acc <= acc_add;
          x <= x_dbl;
          y <= y >> 1;
        end
        dsa_pkg::OP_DIV: begin
          acc <= div_ge ? div_sub[W-1:0] : div_t[W-1:0];
          x   <= {x[W-2:0], div_ge};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign quo = x;
  assign rem = acc;

endmodule

[hw/rtl/dsa_sign_and_verify_unit.sv]
// ----------------------------------------------------------------------------
// dsa_sign_and_verify_unit
// Operation: every shared-unit operation holds its step through the start, the
//   bit iterations and done; an item needs up to about 450 operations.
// Throughput: one item at a time; busy stays high through the done cycle.
// Reset: sequencer idle, configuration back to p=23, q=11, g=4, x=3.
// Results show for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module dsa_sign_and_verify_unit #(
  parameter int NUM_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] message_hash,
  input  logic [NUM_WIDTH-1:0] nonce,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [NUM_WIDTH-1:0] cfg_data,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] public_key,
  output logic [NUM_WIDTH-1:0] sig_r,
  output logic [NUM_WIDTH-1:0] sig_s,
  output logic [NUM_WIDTH-1:0] s_inverse,
  output logic [NUM_WIDTH-1:0] u_first,
  output logic [NUM_WIDTH-1:0] u_second,
  output logic [NUM_WIDTH-1:0] verify_value,
  output logic                 nonce_not_invertible,
  output logic                 s_not_invertible
);

  localparam int W = NUM_WIDTH;

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_PW_INIT = 19'h00002,
    S_PW_BIT  = 19'h00004,
    S_PW_MULF = 19'h00008,
    S_PW_SQR  = 19'h00010,
    S_RMOD    = 19'h00020,
    S_IV_INIT = 19'h00040,
    S_IV_TEST = 19'h00080,
    S_IV_DIV  = 19'h00100,
    S_IV_MUL  = 19'h00200,
    S_XMOD    = 19'h00400,
    S_XR      = 19'h00800,
    S_HMOD    = 19'h01000,
    S_SMUL    = 19'h02000,
    S_U1      = 19'h04000,
    S_U2      = 19'h08000,
    S_VMUL    = 19'h10000,
    S_VMOD    = 19'h20000,
    S_DONE    = 19'h40000
  } state_t;

  // which exponentiation is running
  typedef enum logic [3:0] {
    PJ_Y   = 4'b0001,
    PJ_GK  = 4'b0010,
    PJ_GU1 = 4'b0100,
    PJ_YU2 = 4'b1000
  } pjob_t;

  // which inverse is running
  typedef enum logic [1:0] {
    IJ_K = 2'b01,
    IJ_S = 2'b10
  } ijob_t;

  state_t         state;
  pjob_t          pjob;
  ijob_t          ijob;
  logic           pending;

  logic [W-1:0]   mod_p, ord_q, gen_g, priv_x;
  logic [W-1:0]   hm, k;
  logic [W-1:0]   y, r, s, w, u1, u2, v;
  logic           fk, fs;
  logic [W-1:0]   pbase, pexp, pf, pa;
  logic [W-1:0]   r0, r1, t0, t1, qq;
  logic [W-1:0]   kinv, xq, tprod, hmq, tsum;

  logic           unit_start, unit_done;
  dsa_pkg::op_t   unit_op;
  logic [W-1:0]   unit_a, unit_b, unit_m, unit_quo, unit_rem;
  logic [W-1:0]   pw_base_src, pw_exp_src, iv_src;
  logic           p_small, q_small, iv_fail;
  logic [W:0]     hsum;

  assign p_small   = (mod_p < W'(2));
  assign q_small   = (ord_q < W'(2));
  assign iv_fail   = (r0 != W'(1));
  assign hsum      = {1'b0, unit_rem} + {1'b0, tprod};
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign done      = (state == S_DONE);

  // operands of the running exponentiation and inverse
  always_comb begin
    unique case (pjob)
      PJ_Y:    begin pw_base_src = gen_g; pw_exp_src = priv_x; end
      PJ_GK:   begin pw_base_src = gen_g; pw_exp_src = k;      end
      PJ_GU1:  begin pw_base_src = gen_g; pw_exp_src = u1;     end
      PJ_YU2:  begin pw_base_src = y;     pw_exp_src = u2;     end
      default: begin pw_base_src = gen_g; pw_exp_src = priv_x; end
    endcase
    iv_src = (ijob == IJ_K) ? k : s;
  end

  // shared unit operand select
  always_comb begin
    unit_op = dsa_pkg::OP_DIV;
    unit_a  = '0;
    unit_b  = '0;
    unit_m  = ord_q;
    unique case (state)
      S_PW_INIT: begin unit_a = pw_base_src; unit_m = mod_p; end
      S_PW_MULF: begin
        unit_op = dsa_pkg::OP_MUL; unit_a = pf; unit_b = pbase; unit_m = mod_p;
      end
      S_PW_SQR: begin
        unit_op = dsa_pkg::OP_MUL; unit_a = pbase; unit_b = pbase; unit_m = mod_p;
      end
      S_RMOD:    unit_a = pf;
      S_IV_INIT: unit_a = iv_src;
      S_IV_DIV:  begin unit_a = r0; unit_m = r1; end
      S_IV_MUL:  begin unit_op = dsa_pkg::OP_MUL; unit_a = qq; unit_b = t1; end
      S_XMOD:    unit_a = priv_x;
      S_XR:      begin unit_op = dsa_pkg::OP_MUL; unit_a = xq; unit_b = r; end
      S_HMOD:    unit_a = hm;
      S_SMUL:    begin unit_op = dsa_pkg::OP_MUL; unit_a = kinv; unit_b = tsum; end
      S_U1:      begin unit_op = dsa_pkg::OP_MUL; unit_a = hmq; unit_b = w; end
      S_U2:      begin unit_op = dsa_pkg::OP_MUL; unit_a = r; unit_b = w; end
      S_VMUL: begin
        unit_op = dsa_pkg::OP_MUL; unit_a = pa; unit_b = pf; unit_m = mod_p;
      end
      S_VMOD:    unit_a = pf;
      default:   unit_a = '0;
    endcase
  end

  // issue one unit operation on entry to each arithmetic step (none in S_PW_INIT when p is below 2)
  always_comb begin
    unique case (state)
      S_PW_INIT: unit_start = !pending && !p_small;
      S_PW_MULF, S_PW_SQR, S_RMOD, S_IV_INIT, S_IV_DIV, S_IV_MUL, S_XMOD, S_XR,
      S_HMOD, S_SMUL, S_U1, S_U2, S_VMUL, S_VMOD:
                 unit_start = !pending;
      default:   unit_start = 1'b0;
    endcase
  end

  dsa_arith #(.W(W)) u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .op    (unit_op),
    .a     (unit_a),
    .b     (unit_b),
    .m     (unit_m),
    .done  (unit_done),
    .quo   (unit_quo),
    .rem   (unit_rem)
  );

  // control: sequencer, operation tracking, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
      pjob    <= PJ_Y;
      ijob    <= IJ_K;
      mod_p   <= W'(23);
      ord_q   <= W'(11);
      gen_g   <= W'(4);
      priv_x  <= W'(3);
    end else begin
      // configuration transfer
      if (cfg_valid) begin
        unique case (cfg_index)
          dsa_pkg::REG_P: mod_p  <= cfg_data;
          dsa_pkg::REG_Q: ord_q  <= cfg_data;
          dsa_pkg::REG_G: gen_g  <= cfg_data;
          dsa_pkg::REG_X: priv_x <= cfg_data;
          default:        mod_p  <= mod_p;
        endcase
      end

      if (unit_start) pending <= 1'b1;
      else if (unit_done) pending <= 1'b0;

      unique case (state)
        S_IDLE: if (start) begin
          pjob  <= PJ_Y;
          state <= S_PW_INIT;
        end
        S_PW_INIT: if (p_small || unit_done) state <= S_PW_BIT;
        S_PW_BIT: begin
          if (pexp == '0) begin
            unique case (pjob)
              PJ_Y: begin
                if (q_small) state <= S_DONE;
                else begin
                  pjob  <= PJ_GK;
                  state <= S_PW_INIT;
                end
              end
              PJ_GK:  state <= S_RMOD;
              PJ_GU1: begin
                pjob  <= PJ_YU2;
                state <= S_PW_INIT;
              end
              PJ_YU2: state <= S_VMUL;
              default: state <= S_IDLE;
            endcase
          end else if (pexp[0]) state <= S_PW_MULF;
          else state <= S_PW_SQR;
        end
        S_PW_MULF: if (unit_done) state <= S_PW_SQR;
        S_PW_SQR:  if (unit_done) state <= S_PW_BIT;
        S_RMOD: if (unit_done) begin
          ijob  <= IJ_K;
          state <= S_IV_INIT;
        end
        S_IV_INIT: if (unit_done) state <= S_IV_TEST;
        S_IV_TEST: begin
          if (r1 == '0) state <= (ijob == IJ_K) ? S_XMOD : S_U1;
          else state <= S_IV_DIV;
        end
        S_IV_DIV: if (unit_done) state <= S_IV_MUL;
        S_IV_MUL: if (unit_done) state <= S_IV_TEST;
        S_XMOD:   if (unit_done) state <= S_XR;
        S_XR:     if (unit_done) state <= S_HMOD;
        S_HMOD:   if (unit_done) state <= S_SMUL;
        S_SMUL: if (unit_done) begin
          ijob  <= IJ_S;
          state <= S_IV_INIT;
        end
        S_U1: if (unit_done) state <= S_U2;
        S_U2: if (unit_done) begin
          if (p_small) state <= S_DONE;
          else begin
            pjob  <= PJ_GU1;
            state <= S_PW_INIT;
          end
        end
        S_VMUL: if (unit_done) state <= S_VMOD;
        S_VMOD: if (unit_done) state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (start) begin
        hm <= message_hash;
        k  <= nonce;
      end
      S_PW_INIT: begin
        if (p_small) begin
          pf   <= '0;
          pexp <= '0;
        end else if (unit_done) begin
          pbase <= unit_rem;
          pf    <= W'(1);
          pexp  <= pw_exp_src;
        end
      end
      S_PW_BIT: if (pexp == '0) begin
        unique case (pjob)
          PJ_Y: begin
            y <= pf;
            if (q_small) begin
              r  <= '0; s  <= '0; w <= '0;
              u1 <= '0; u2 <= '0; v <= '0;
              fk <= 1'b1; fs <= 1'b1;
            end
          end
          PJ_GU1:  pa <= pf;
          default: pa <= pa;
        endcase
      end
      S_PW_MULF: if (unit_done) pf <= unit_rem;
      S_PW_SQR: if (unit_done) begin
        pbase <= unit_rem;
        pexp  <= pexp >> 1;
      end
      S_RMOD: if (unit_done) r <= unit_rem;
      S_IV_INIT: if (unit_done) begin
        r0 <= ord_q;
        r1 <= unit_rem;
        t0 <= '0;
        t1 <= W'(1);
      end
      S_IV_TEST: if (r1 == '0) begin
        if (ijob == IJ_K) begin
          kinv <= iv_fail ? '0 : t0;
          fk   <= iv_fail;
        end else begin
          w  <= iv_fail ? '0 : t0;
          fs <= iv_fail;
        end
      end
      S_IV_DIV: if (unit_done) begin
        r0 <= r1;
        r1 <= unit_rem;
        qq <= (unit_quo >= ord_q) ? unit_quo - ord_q : unit_quo;
      end
      S_IV_MUL: if (unit_done) begin
        t0 <= t1;
        t1 <= (t0 >= unit_rem) ? t0 - unit_rem : t0 + (ord_q - unit_rem);
      end
      S_XMOD: if (unit_done) xq <= unit_rem;
      S_XR:   if (unit_done) tprod <= unit_rem;
      S_HMOD: if (unit_done) begin
        hmq  <= unit_rem;
        tsum <= (hsum >= {1'b0, ord_q}) ? W'(hsum - {1'b0, ord_q}) : hsum[W-1:0];
      end
      S_SMUL: if (unit_done) s <= unit_rem;
      S_U1:   if (unit_done) u1 <= unit_rem;
      S_U2: if (unit_done) begin
        u2 <= unit_rem;
        if (p_small) v <= '0;
      end
      S_VMUL: if (unit_done) pf <= unit_rem;
      S_VMOD: if (unit_done) v <= unit_rem;
      default: hm <= hm;
    endcase
  end

  // result ports
  assign public_key           = y;
  assign sig_r                = r;
  assign sig_s                = s;
  assign s_inverse            = w;
  assign u_first              = u1;
  assign u_second             = u2;
  assign verify_value         = v;
  assign nonce_not_invertible = fk;
  assign s_not_invertible     = fs;

endmodule
